// ----- rtl/pulse_period_flow_and_fan_meter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pulse period flow and fan meter
// Concurrent checks sampled on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_PERIOD_FLOW_AND_FAN_METER_DEFINES_SVH
`define PULSE_PERIOD_FLOW_AND_FAN_METER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPFM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ppfm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppfm_pkg
// Shared types, constants and codes of the pulse period flow and fan meter.
// ----------------------------------------------------------------------------
package ppfm_pkg;

	// Averaging depth and field widths.
	localparam int FILTER_COUNT = 10;
	localparam int CNT_W        = 16;
	localparam int SUM_W        = 20;
	localparam int AVG_W        = 4;
	localparam int FLOW_W       = 10;
	localparam int FAN_W        = 16;
	localparam int STEP_W       = 8;

	// Divider geometry: two quotient bits per cycle.
	localparam int DIV_N_W      = 20;
	localparam int DIV_D_W      = 16;
	localparam int DIV_BITS     = 2;
	localparam int DIV_STEPS    = DIV_N_W / DIV_BITS;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	// Conversion numerators and offset.
	localparam logic [DIV_N_W-1:0] FLOW_NUM = DIV_N_W'(1000000);
	localparam logic [DIV_N_W-1:0] FAN_NUM  = DIV_N_W'(150000);
	localparam logic [SUM_W-1:0]   FLOW_OFS = SUM_W'(300);

	// Division by constants through reciprocal multiplication.
	// Both reciprocals are rounded up and exact for every 20-bit operand.
	localparam int MUL_W      = 27;
	localparam int PROD_W     = SUM_W + MUL_W;
	localparam int R81_SHIFT  = 27;
	localparam int R81_MUL    = ((2 ** R81_SHIFT) + 80) / 81;
	localparam int AVG_SHIFT  = 25;
	localparam int AVG_MUL    = ((2 ** AVG_SHIFT) + FILTER_COUNT - 1) / FILTER_COUNT;

	// Operation codes passed from the front end to the back end.
	typedef logic [1:0] op_t;
	localparam op_t OP_COUNT = 2'd0;
	localparam op_t OP_PULSE = 2'd1;
	localparam op_t OP_EVAL  = 2'd2;
	localparam op_t OP_NOP   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [1:0] CFG_STEP     = 2'd1;
	localparam logic [1:0] CFG_LOW_FLOW = 2'd2;
	localparam logic [1:0] CFG_FLOW_MAX = 2'd3;

	// Configuration reset values.
	localparam logic [CNT_W-1:0]  RST_TIMEOUT  = CNT_W'(1000);
	localparam logic [STEP_W-1:0] RST_STEP     = STEP_W'(5);
	localparam logic [FLOW_W-1:0] RST_LOW_FLOW = FLOW_W'(30);
	localparam logic [FLOW_W-1:0] RST_FLOW_MAX = FLOW_W'(250);

	// Queue between front and back.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		op_t  op;
		logic ch;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  timeout_limit;
		logic [STEP_W-1:0] step_threshold;
		logic [FLOW_W-1:0] low_flow_limit;
		logic [FLOW_W-1:0] flow_max;
	} cfg_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic out_load;
		logic div_busy;
	} back_stat_t;

endpackage

// ----- rtl/pulse_period_flow_and_fan_meter.sv -----
// Count, pulse and unused requests pass through the queue and then load the result
// register. An evaluate request runs per channel through the check, a divider run (two
// quotient bits per cycle) and the multiply, cap and averaging steps, flow first and then
// fan, and then loads the result.
// Throughput: one request at a time in the back end; the 4-entry queue absorbs bursts.
// Reset: arst_n clears all counters, buffers, sums and values and loads the defaults.
// ----------------------------------------------------------------------------
// pulse_period_flow_and_fan_meter
// Two-channel tachometer with median-of-three periods and output averaging.
// ----------------------------------------------------------------------------
`include "pulse_period_flow_and_fan_meter_defines.svh"

module pulse_period_flow_and_fan_meter import ppfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic              sensor,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [FLOW_W-1:0] flow_value,
	output logic [FAN_W-1:0]  fan_speed,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	cfg_t       cfg_q;
	logic       push;
	item_t      push_item;
	item_t      q_head;
	logic       q_pop;
	q_stat_t    q_stat;
	back_stat_t back_stat;

	// Configuration registers; a write is always accepted, as cfg_ready is tied high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_limit  <= RST_TIMEOUT;
			cfg_q.step_threshold <= RST_STEP;
			cfg_q.low_flow_limit <= RST_LOW_FLOW;
			cfg_q.flow_max       <= RST_FLOW_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TIMEOUT:  cfg_q.timeout_limit  <= cfg_data;
				CFG_STEP:     cfg_q.step_threshold <= cfg_data[STEP_W-1:0];
				CFG_LOW_FLOW: cfg_q.low_flow_limit <= cfg_data[FLOW_W-1:0];
				CFG_FLOW_MAX: cfg_q.flow_max       <= cfg_data[FLOW_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Request decode.
	ppfm_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.sensor    (sensor),
		.q_full    (q_stat.full),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	ppfm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// Measurement engine.
	ppfm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (!q_stat.empty),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.flow_value (flow_value),
		.fan_speed  (fan_speed),
		.stat       (back_stat)
	);

	// Design checks.
	`PPFM_ASSERT_SAME(a_load_free, back_stat.out_load, !out_valid || !out_stall, "result register overwritten")
	`PPFM_ASSERT_NEXT(a_load_shows, back_stat.out_load, out_valid, "loaded result not presented")
	`PPFM_ASSERT_SAME(a_div_in_eval, back_stat.div_busy, back_stat.busy, "divider running while idle")
	`PPFM_ASSERT_SAME(a_q_bound, q_pop, !q_stat.empty, "pop from empty queue")

endmodule

// ----- rtl/ppfm_div.sv -----
// ----------------------------------------------------------------------------
// ppfm_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ppfm_div import ppfm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [DIV_N_W-1:0] quotient
);

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W-1:0]   rem_nxt;
	logic [DIV_N_W-1:0]   quo_nxt;

	// Two dependent shift-and-subtract steps per cycle.
	always_comb begin
		logic [DIV_D_W:0] trial;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial   = {rem_nxt, quo_nxt[DIV_N_W-1]};
			quo_nxt = {quo_nxt[DIV_N_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial      = trial - {1'b0, dvs_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = trial[DIV_D_W-1:0];
		end
	end

	// Iteration control; done pulses for one cycle with the quotient ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/ppfm_fifo.sv -----
// ----------------------------------------------------------------------------
// ppfm_fifo
// Short queue of decoded requests between the front end and the back end.
// ----------------------------------------------------------------------------
module ppfm_fifo import ppfm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t stat
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointer and fill tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// ----- rtl/ppfm_front.sv -----
// ----------------------------------------------------------------------------
// ppfm_front
// Input side: takes request transactions and decodes them into queue entries.
// ----------------------------------------------------------------------------
module ppfm_front import ppfm_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic       sensor,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	// Only pulse edges carry a channel; the other requests drop it.
	always_comb begin
		push_item.ch = 1'b0;
		case (req_type)
			OP_COUNT: push_item.op = OP_COUNT;
			OP_PULSE: begin
				push_item.op = OP_PULSE;
				push_item.ch = sensor;
			end
			OP_EVAL:  push_item.op = OP_EVAL;
			default:  push_item.op = OP_NOP;
		endcase
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

// ----- rtl/ppfm_back.sv -----
// ----------------------------------------------------------------------------
// ppfm_back
// Execution side: period counters, capture buffers, conversion and averaging.
// ----------------------------------------------------------------------------
module ppfm_back import ppfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [FLOW_W-1:0] flow_value,
	output logic [FAN_W-1:0]  fan_speed,
	output back_stat_t        stat
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CHECK   = 4'd1;
	localparam logic [3:0] ST_CONV    = 4'd2;
	localparam logic [3:0] ST_DIV     = 4'd3;
	localparam logic [3:0] ST_MUL81   = 4'd4;
	localparam logic [3:0] ST_SHIFT81 = 4'd5;
	localparam logic [3:0] ST_CAP     = 4'd6;
	localparam logic [3:0] ST_APPLY   = 4'd7;
	localparam logic [3:0] ST_AVGMUL  = 4'd8;
	localparam logic [3:0] ST_AVGSET  = 4'd9;
	localparam logic [3:0] ST_EMIT    = 4'd10;

	logic [3:0]        state_q;
	logic              ch_q;
	logic [CNT_W-1:0]  pcnt_q [2];
	logic [CNT_W-1:0]  pbuf_q [2][3];
	logic [1:0]        cap_q  [2];
	logic              full_q [2];
	logic [AVG_W-1:0]  avg_q  [2];
	logic [SUM_W-1:0]  sum_q  [2];
	logic [FLOW_W-1:0] flow_val_q;
	logic [FAN_W-1:0]  fan_val_q;
	logic [CNT_W-1:0]  p_q;
	logic [SUM_W-1:0]  r_q;
	logic [FAN_W-1:0]  v_q;
	logic [PROD_W-1:0] prod_q;
	logic              out_valid_q;
	logic [FLOW_W-1:0] flow_out_q;
	logic [FAN_W-1:0]  fan_out_q;

	logic              out_free;
	logic              out_load;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [DIV_N_W-1:0] div_quo;
	logic [CNT_W-1:0]  lo;
	logic [CNT_W-1:0]  hi;
	logic [CNT_W-1:0]  med;
	logic              timed_out;
	logic              jump;
	logic [SUM_W-1:0]  sum_add;
	logic [SUM_W-1:0]  sum_cap;
	logic [SUM_W-1:0]  sum_new;
	logic [AVG_W-1:0]  avg_new;
	logic [FAN_W-1:0]  r_capped;
	logic [SUM_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;

	// Shared divider for the period conversions.
	ppfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ch_q ? FAN_NUM : FLOW_NUM),
		.divisor  (p_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Median of the selected channel; lo and hi are written back sorted.
	always_comb begin
		logic [CNT_W-1:0] b0;
		logic [CNT_W-1:0] b1;
		logic [CNT_W-1:0] b2;
		b0  = pbuf_q[ch_q][0];
		b1  = pbuf_q[ch_q][1];
		b2  = pbuf_q[ch_q][2];
		lo  = (b1 < b0) ? b1 : b0;
		hi  = (b1 < b0) ? b0 : b1;
		if (b2 >= lo && b2 <= hi) begin
			med = b2;
		end else if (b2 < lo) begin
			med = lo;
		end else begin
			med = hi;
		end
	end

	// Timeout, jump detection and running sum update.
	always_comb begin
		logic [CNT_W:0] v17;
		logic [CNT_W:0] cur17;
		logic [CNT_W:0] st17;
		v17       = {1'b0, v_q};
		cur17     = (CNT_W+1)'(flow_val_q);
		st17      = (CNT_W+1)'(cfg.step_threshold);
		timed_out = (pcnt_q[ch_q] >= cfg.timeout_limit);
		jump      = !ch_q && ((v17 >= cur17 + st17) || (cur17 >= v17 + st17)) &&
			(flow_val_q <= cfg.low_flow_limit);
		sum_add   = sum_q[ch_q] + SUM_W'(v_q);
		sum_cap   = SUM_W'(cfg.flow_max) * SUM_W'(FILTER_COUNT);
		sum_new   = (!ch_q && sum_add > sum_cap) ? sum_cap : sum_add;
		avg_new   = avg_q[ch_q] + 1'b1;
	end

	// Caps on the converted value.
	always_comb begin
		r_capped = (r_q > SUM_W'(16'hFFFF)) ? 16'hFFFF : r_q[FAN_W-1:0];
		if (!ch_q && r_capped > FAN_W'(cfg.flow_max)) begin
			r_capped = FAN_W'(cfg.flow_max);
		end
	end

	// One shared constant multiplier for both reciprocal divisions.
	always_comb begin
		if (state_q == ST_MUL81) begin
			mul_a = r_q;
			mul_b = MUL_W'(R81_MUL);
		end else begin
			mul_a = sum_q[ch_q];
			mul_b = MUL_W'(AVG_MUL);
		end
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && out_free;
	assign out_load  = (q_pop && q_item.op != OP_EVAL) || (state_q == ST_EMIT);
	assign div_start = (state_q == ST_CONV) && (p_q != '0);

	// Sequencer and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			flow_val_q  <= '0;
			fan_val_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				pcnt_q[i] <= '0;
				cap_q[i]  <= '0;
				full_q[i] <= 1'b0;
				avg_q[i]  <= '0;
				sum_q[i]  <= '0;
				for (int k = 0; k < 3; k++) begin
					pbuf_q[i][k] <= '0;
				end
			end
		end else begin
			// A result stays valid until taken, unless a new one is loaded.
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.op)
							OP_COUNT: begin
								for (int i = 0; i < 2; i++) begin
									if (pcnt_q[i] != 16'hFFFF) begin
										pcnt_q[i] <= pcnt_q[i] + 1'b1;
									end
								end
							end
							OP_PULSE: begin
								if (cap_q[q_item.ch] != 2'd3) begin
									for (int k = 0; k < 3; k++) begin
										if (cap_q[q_item.ch] == 2'(k)) begin
											pbuf_q[q_item.ch][k] <= pcnt_q[q_item.ch];
										end
									end
									cap_q[q_item.ch] <= cap_q[q_item.ch] + 1'b1;
									if (cap_q[q_item.ch] == 2'd2) begin
										full_q[q_item.ch] <= 1'b1;
									end
								end
								pcnt_q[q_item.ch] <= '0;
							end
							OP_EVAL: begin
								ch_q    <= 1'b0;
								state_q <= ST_CHECK;
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					if (timed_out) begin
						pcnt_q[ch_q] <= cfg.timeout_limit;
						if (ch_q) begin
							fan_val_q <= '0;
							state_q   <= ST_EMIT;
						end else begin
							flow_val_q <= '0;
							ch_q       <= 1'b1;
						end
					end else if (!full_q[ch_q]) begin
						if (ch_q) begin
							state_q <= ST_EMIT;
						end else begin
							ch_q <= 1'b1;
						end
					end else begin
						pbuf_q[ch_q][0] <= lo;
						pbuf_q[ch_q][1] <= hi;
						state_q         <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (p_q == '0) begin
						state_q <= ST_CAP;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ch_q ? ST_CAP : ST_MUL81;
					end
				end
				ST_MUL81:   state_q <= ST_SHIFT81;
				ST_SHIFT81: state_q <= ST_CAP;
				ST_CAP:     state_q <= ST_APPLY;
				ST_APPLY: begin
					if (jump) begin
						flow_val_q <= v_q[FLOW_W-1:0];
						avg_q[0]   <= '0;
						sum_q[0]   <= '0;
						state_q    <= ST_EMIT;
					end else begin
						avg_q[ch_q]  <= avg_new;
						sum_q[ch_q]  <= sum_new;
						cap_q[ch_q]  <= '0;
						full_q[ch_q] <= 1'b0;
						if (avg_new >= AVG_W'(FILTER_COUNT)) begin
							state_q <= ST_AVGMUL;
						end else if (ch_q) begin
							state_q <= ST_EMIT;
						end else begin
							ch_q    <= 1'b1;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_AVGMUL: state_q <= ST_AVGSET;
				ST_AVGSET: begin
					avg_q[ch_q] <= '0;
					sum_q[ch_q] <= '0;
					if (ch_q) begin
						fan_val_q <= prod_q[AVG_SHIFT +: FAN_W];
						state_q   <= ST_EMIT;
					end else begin
						flow_val_q <= prod_q[AVG_SHIFT +: FLOW_W];
						ch_q       <= 1'b1;
						state_q    <= ST_CHECK;
					end
				end
				ST_EMIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the conversion.
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			p_q <= med;
		end
		if (state_q == ST_CONV && p_q == '0) begin
			r_q <= SUM_W'(20'hFFFF);
		end
		if (state_q == ST_DIV && div_done) begin
			r_q <= ch_q ? div_quo : div_quo + FLOW_OFS;
		end
		if (state_q == ST_SHIFT81) begin
			r_q <= prod_q[R81_SHIFT +: SUM_W];
		end
		if (state_q == ST_CAP) begin
			v_q <= r_capped;
		end
		if (state_q == ST_MUL81 || state_q == ST_AVGMUL) begin
			prod_q <= prod;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			flow_out_q <= flow_val_q;
			fan_out_q  <= fan_val_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign flow_value    = flow_out_q;
	assign fan_speed     = fan_out_q;
	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.out_load = out_load;
	assign stat.div_busy = div_busy;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the pulse period flow and fan meter
// Drives count, pulse, evaluate and unused requests through the valid/stall
// input channel, programs the four registers between phases and checks every
// flow and fan reading against a predictor that tracks the period counters,
// median buffers, averaging and flow jumps of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import ppfm_pkg::*;

	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_TICKS    = 70;
	localparam int PHASE_ITEMS   = 250;
	localparam int REPORT_LIMIT  = 10;
	localparam int IDLE_PERCENT  = 6;

	localparam logic [CNT_W-1:0] COUNT_CEILING = 16'hFFFF;
	localparam int unsigned RATE_CEILING = 32'hFFFF;
	localparam int unsigned FLOW_SCALE   = 1000000;
	localparam int unsigned FLOW_OFFSET  = 300;
	localparam int unsigned FLOW_DIVISOR = 81;
	localparam int unsigned FAN_SCALE    = 150000;
	localparam int unsigned SET_SIZE     = 3;

	localparam bit FLOW_CH = 1'b0;
	localparam bit FAN_CH  = 1'b1;

	typedef struct packed {
		logic [FLOW_W-1:0] flow;
		logic [FAN_W-1:0]  fan;
	} reading_t;

	// Predicts the reading after every accepted request and checks the results.
	class meter_scoreboard;
		logic [CNT_W-1:0]  timeout_limit;
		logic [STEP_W-1:0] step_threshold;
		logic [FLOW_W-1:0] low_flow_limit;
		logic [FLOW_W-1:0] flow_max;
		logic [CNT_W-1:0]  period_cnt [2];
		logic [CNT_W-1:0]  periods [2][3];
		logic [1:0]        captured [2];
		logic              set_full [2];
		logic [AVG_W-1:0]  avg_cnt [2];
		logic [SUM_W-1:0]  rate_sum [2];
		logic [FAN_W-1:0]  rate_value [2];
		reading_t          expected_readings [$];
		int mismatches;
		int results_seen;
		int evaluations;
		int stopped_channels;
		int flow_jumps;
		int average_updates;

		function new();
			timeout_limit  = RST_TIMEOUT;
			step_threshold = RST_STEP;
			low_flow_limit = RST_LOW_FLOW;
			flow_max       = RST_FLOW_MAX;
			for (int i = 0; i < 2; i++) begin
				period_cnt[i] = '0;
				captured[i]   = '0;
				set_full[i]   = 1'b0;
				avg_cnt[i]    = '0;
				rate_sum[i]   = '0;
				rate_value[i] = '0;
				for (int k = 0; k < 3; k++)
					periods[i][k] = '0;
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [CNT_W-1:0] data);
			case (idx)
				CFG_TIMEOUT:  timeout_limit  = data;
				CFG_STEP:     step_threshold = data[STEP_W-1:0];
				CFG_LOW_FLOW: low_flow_limit = data[FLOW_W-1:0];
				CFG_FLOW_MAX: flow_max       = data[FLOW_W-1:0];
				default: ;
			endcase
		endfunction

		// Median of the three captured periods; entries 0 and 1 end up sorted.
		function logic [CNT_W-1:0] middle_period(bit ch);
			logic [CNT_W-1:0] t;
			if (periods[ch][1] < periods[ch][0]) begin
				t = periods[ch][0];
				periods[ch][0] = periods[ch][1];
				periods[ch][1] = t;
			end
			if (periods[ch][2] >= periods[ch][0] && periods[ch][2] <= periods[ch][1])
				return periods[ch][2];
			if (periods[ch][2] < periods[ch][0])
				return periods[ch][0];
			return periods[ch][1];
		endfunction

		// A zero period saturates before the flow cap is applied.
		function int unsigned period_to_rate(bit ch, int unsigned p);
			int unsigned r;
			if (p == 0)
				r = RATE_CEILING;
			else if (ch == FLOW_CH)
				r = (FLOW_SCALE / p + FLOW_OFFSET) / FLOW_DIVISOR;
			else
				r = FAN_SCALE / p;
			if (r > RATE_CEILING)
				r = RATE_CEILING;
			if (ch == FLOW_CH && r > flow_max)
				r = flow_max;
			return r;
		endfunction

		// Returns 1 when a flow jump ends the evaluation.
		function bit update_channel(bit ch);
			int unsigned v;
			int unsigned cur;
			if (period_cnt[ch] >= timeout_limit) begin
				period_cnt[ch] = timeout_limit;
				rate_value[ch] = '0;
				stopped_channels++;
				return 1'b0;
			end
			if (!set_full[ch])
				return 1'b0;
			v = period_to_rate(ch, middle_period(ch));
			if (ch == FLOW_CH) begin
				cur = rate_value[FLOW_CH];
				if ((v >= cur + step_threshold || cur >= v + step_threshold) &&
						cur <= low_flow_limit) begin
					rate_value[FLOW_CH] = v[FAN_W-1:0];
					avg_cnt[FLOW_CH] = '0;
					rate_sum[FLOW_CH] = '0;
					flow_jumps++;
					return 1'b1;
				end
			end
			avg_cnt[ch] = avg_cnt[ch] + 1'b1;
			rate_sum[ch] = SUM_W'(rate_sum[ch] + v);
			if (ch == FLOW_CH && rate_sum[FLOW_CH] > flow_max * FILTER_COUNT)
				rate_sum[FLOW_CH] = SUM_W'(flow_max * FILTER_COUNT);
			if (avg_cnt[ch] >= FILTER_COUNT) begin
				avg_cnt[ch] = '0;
				rate_value[ch] = FAN_W'(rate_sum[ch] / FILTER_COUNT);
				rate_sum[ch] = '0;
				average_updates++;
			end
			captured[ch] = '0;
			set_full[ch] = 1'b0;
			return 1'b0;
		endfunction

		function void note_request(op_t op, logic ch);
			case (op)
				OP_COUNT: begin
					for (int i = 0; i < 2; i++) begin
						if (period_cnt[i] != COUNT_CEILING)
							period_cnt[i]++;
					end
				end
				OP_PULSE: begin
					if (captured[ch] < SET_SIZE) begin
						periods[ch][captured[ch]] = period_cnt[ch];
						captured[ch]++;
						if (captured[ch] >= SET_SIZE)
							set_full[ch] = 1'b1;
					end
					period_cnt[ch] = '0;
				end
				OP_EVAL: begin
					evaluations++;
					if (!update_channel(FLOW_CH))
						void'(update_channel(FAN_CH));
				end
				default: ;
			endcase
			expected_readings.push_back({rate_value[FLOW_CH][FLOW_W-1:0], rate_value[FAN_CH]});
		endfunction

		function void check_reading(logic [FLOW_W-1:0] flow, logic [FAN_W-1:0] fan);
			reading_t exp_r;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected reading: flow %0d fan %0d", flow, fan);
				return;
			end
			exp_r = expected_readings.pop_front();
			results_seen++;
			if (exp_r.flow !== flow || exp_r.fan !== fan) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("reading %0d mismatch: flow expected %0d got %0d, fan expected %0d got %0d",
						results_seen, exp_r.flow, flow, exp_r.fan, fan);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        req_type;
	logic              sensor;
	logic              out_valid;
	logic              out_stall;
	logic [FLOW_W-1:0] flow_value;
	logic [FAN_W-1:0]  fan_speed;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [CNT_W-1:0]  cfg_data;

	bit idle_on;
	int holds_asked;
	int holds_granted;
	int hold_left;
	int cycle_count;
	int requests_sent;

	meter_scoreboard sb = new();

	pulse_period_flow_and_fan_meter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.sensor     (sensor),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.flow_value (flow_value),
		.fan_speed  (fan_speed),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Clock generation.
	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: long hold-offs on request, otherwise occasional random stalls.
	always @(posedge clk) begin
		if (holds_granted < holds_asked) begin
			holds_granted++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Every result transaction is checked against the oldest expected reading.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reading(flow_value, fan_speed);
	end

	// Offers one request and returns at the edge that accepts it.
	task automatic send_request(input op_t op, input logic ch);
		while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		sensor   <= ch;
		do @(posedge clk); while (in_stall);
		sb.note_request(op, ch);
		requests_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high so that writes can follow back to back.
	task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
	endtask

	task automatic program_meter(input logic [CNT_W-1:0] timeout, input logic [STEP_W-1:0] step,
			input logic [FLOW_W-1:0] low_flow, input logic [FLOW_W-1:0] cap);
		wait_drained();
		write_reg(CFG_TIMEOUT, timeout);
		write_reg(CFG_STEP, CNT_W'(step));
		write_reg(CFG_LOW_FLOW, CNT_W'(low_flow));
		write_reg(CFG_FLOW_MAX, CNT_W'(cap));
		cfg_valid <= 1'b0;
	endtask

	// One measurement round: ticks and pulses toward a full set on each channel,
	// with dropped and extra pulses, trailing ticks and a closing evaluation.
	task automatic random_period_set(input int max_gap);
		int gap;
		logic first_ch;
		for (int k = 0; k < 3; k++) begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4 * max_gap)
				: $urandom_range(0, max_gap);
			repeat (gap) send_request(OP_COUNT, 1'($urandom_range(0, 1)));
			first_ch = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) != 0)
				send_request(OP_PULSE, first_ch);
			if ($urandom_range(0, 9) != 0)
				send_request(OP_PULSE, !first_ch);
		end
		if ($urandom_range(0, 9) == 0)
			send_request(OP_PULSE, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(0, max_gap)) send_request(OP_COUNT, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 19) == 0)
			send_request(OP_NOP, 1'($urandom_range(0, 1)));
		send_request(OP_EVAL, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 19) == 0)
			send_request(OP_EVAL, 1'($urandom_range(0, 1)));
	endtask

	task automatic run_random(input int n_items, input int max_gap);
		int stop_at;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat (8)
					send_request(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			end else begin
				random_period_set(max_gap);
			end
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = OP_COUNT;
		sensor    = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data  = '0;
		idle_on   = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused requests, empty evaluation, zero periods, full buffer,
		// flow jump skipping fan, then a fan set that needs reordering.
		send_request(OP_NOP, 1'b0);
		send_request(OP_NOP, 1'b1);
		send_request(OP_EVAL, 1'b1);
		repeat (4) send_request(OP_PULSE, 1'b0);
		repeat (3) send_request(OP_PULSE, 1'b1);
		send_request(OP_EVAL, 1'b0);
		send_request(OP_EVAL, 1'b1);
		repeat (3) send_request(OP_COUNT, 1'b1);
		send_request(OP_PULSE, 1'b1);
		repeat (2) send_request(OP_COUNT, 1'b0);
		send_request(OP_PULSE, 1'b1);
		send_request(OP_PULSE, 1'b1);
		send_request(OP_EVAL, 1'b0);

		// Long periods back to back with no idling: two stretches of ticks, an
		// evaluation in between, then a set built from the long periods. A zero
		// step makes the converted flow show up at once.
		program_meter(16'hFFFF, 8'd0, 10'd1023, 10'd1023);
		idle_on = 1'b0;
		repeat (LONG_TICKS) send_request(OP_COUNT, 1'($urandom_range(0, 1)));
		send_request(OP_EVAL, 1'b0);
		send_request(OP_PULSE, 1'b0);
		send_request(OP_PULSE, 1'b1);
		repeat (LONG_TICKS) send_request(OP_COUNT, 1'($urandom_range(0, 1)));
		repeat (2) begin
			send_request(OP_PULSE, 1'b0);
			send_request(OP_PULSE, 1'b1);
		end
		send_request(OP_EVAL, 1'b1);
		idle_on = 1'b1;
		run_random(PHASE_ITEMS, 40);

		program_meter(16'd1, 8'd255, 10'd0, 10'd1);
		run_random(PHASE_ITEMS, 4);

		// The receiver holds off while requests keep coming.
		program_meter(16'd8, 8'd20, 10'd500, 10'd600);
		holds_asked++;
		run_random(PHASE_ITEMS, 15);

		program_meter(16'd200, 8'd3, 10'd1023, 10'd1023);
		idle_on = 1'b0;
		run_random(PHASE_ITEMS, 25);
		idle_on = 1'b1;

		// Back to the reset values, with a hold-off and a full drain midway.
		program_meter(RST_TIMEOUT, RST_STEP, RST_LOW_FLOW, RST_FLOW_MAX);
		holds_asked++;
		run_random(PHASE_ITEMS / 2, 12);
		wait_drained();
		run_random(PHASE_ITEMS / 2, 12);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests over six register settings, %0d readings checked, %0d evaluations",
			requests_sent, sb.results_seen, sb.evaluations);
		$display("%0d stopped channels, %0d flow jumps, %0d averaged updates",
			sb.stopped_channels, sb.flow_jumps, sb.average_updates);
		if (sb.mismatches > REPORT_LIMIT)
			$display("%0d mismatches in total", sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
